// ===== hdl/stc_pkg.sv =====
// Package with the token codes, character constants and result type of the token classifier.
`default_nettype none

package stc_pkg;

	localparam int LENGTH_LIMIT_DEF = 255;
	localparam int MAX_RESULTS = 4;
	localparam int VALUE_W = 31;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;
	localparam int LEN_OUT_MAX = 255;

	localparam logic [2:0] KIND_NUMBER    = 3'd0;
	localparam logic [2:0] KIND_MALFORMED = 3'd1;
	localparam logic [2:0] KIND_IDENT     = 3'd2;
	localparam logic [2:0] KIND_RESERVED  = 3'd3;
	localparam logic [2:0] KIND_SPECIAL   = 3'd4;
	localparam logic [2:0] KIND_LONE_LT   = 3'd5;
	localparam logic [2:0] KIND_OPERATOR  = 3'd6;

	localparam logic [1:0] KW_COUT  = 2'd0;
	localparam logic [1:0] KW_FOR   = 2'd1;
	localparam logic [1:0] KW_INT   = 2'd2;
	localparam logic [1:0] KW_WHILE = 2'd3;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_DIGIT = 2'd1;
	localparam logic [1:0] MODE_WORD  = 2'd2;

	localparam logic [1:0] LTP_NONE = 2'd0;
	localparam logic [1:0] LTP_LT   = 2'd1;
	localparam logic [1:0] LTP_COUT = 2'd2;

	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic [2:0]         kind;
		logic [1:0]         kw;
		logic [7:0]         sym;
		logic [7:0]         len;
		logic [VALUE_W-1:0] val;
	} result_t;

	// Length of each keyword; cout is matched without its trailing << here.
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] l;
		case (k)
			KW_COUT:  l = 3'd4;
			KW_FOR:   l = 3'd3;
			KW_INT:   l = 3'd3;
			KW_WHILE: l = 3'd5;
			default:  l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [39:0] txt;
		case (k)
			KW_COUT:  txt = {8'h00, "tuoc"};
			KW_FOR:   txt = {16'h0000, "rof"};
			KW_INT:   txt = {16'h0000, "tni"};
			KW_WHILE: txt = "elihw";
			default:  txt = '0;
		endcase
		case (pos)
			3'd0:    return txt[7:0];
			3'd1:    return txt[15:8];
			3'd2:    return txt[23:16];
			3'd3:    return txt[31:24];
			3'd4:    return txt[39:32];
			default: return 8'h00;
		endcase
	endfunction

	function automatic result_t mk_result(input logic [2:0] kind, input logic [1:0] kw,
			input logic [7:0] sym, input logic [7:0] len);
		result_t r;
		r.kind = kind;
		r.kw   = kw;
		r.sym  = sym;
		r.len  = len;
		r.val  = '0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/statement_token_classifier.sv =====
// Top level of the statement token classifier: scanner state, result buffer and output.
// The first result of a character is offered in the cycle after its beat is taken.
// Throughput: one character per cycle while each yields at most one result and out_stall
// is low; a character that yields more (up to four) holds the input until the four-entry
// result buffer has sent its last beat, draining one beat per cycle while not stalled.
// Reset: arst_n clears the scanner state and empties the result buffer.
`default_nettype none

module statement_token_classifier #(
	parameter int LENGTH_LIMIT = stc_pkg::LENGTH_LIMIT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] character,
	input  wire logic       end_of_statement,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      token_kind,
	output logic [1:0]      keyword_index,
	output logic [7:0]      symbol_code,
	output logic [7:0]      token_length,
	output logic [30:0]     number_value,
	output logic            last_result
);
	import stc_pkg::*;

	localparam int LEN_W = $clog2(LENGTH_LIMIT + 1);
	localparam int RW = (LEN_W > 8) ? LEN_W : 8;
	localparam int NCAND = 8;

	typedef struct packed {
		logic [1:0]         mode;
		logic [LEN_W-1:0]   len;
		logic [VALUE_W-1:0] acc;
		logic               dig;
		logic [3:0]         cand;
		logic [1:0]         ltp;
	} scan_t;

	scan_t   st_q, st_d;
	result_t res_s1 [MAX_RESULTS];
	result_t lst [MAX_RESULTS];
	logic [2:0] cnt_s1, n_new;
	logic [1:0] idx_q;
	logic       in_take, out_take, at_last;

	logic    cv [NCAND];
	result_t cr [NCAND];
	logic    c_digit, c_alpha, c_word, c_special, c_oper;

	function automatic logic [7:0] rep_len(input logic [LEN_W-1:0] l);
		logic [RW-1:0] e;
		e = RW'(l);
		return (e > RW'(LEN_OUT_MAX)) ? 8'(LEN_OUT_MAX) : e[7:0];
	endfunction

	function automatic scan_t cleared(input scan_t s);
		scan_t t;
		t      = s;
		t.mode = MODE_NONE;
		t.len  = '0;
		t.acc  = '0;
		t.dig  = 1'b1;
		t.cand = 4'hF;
		return t;
	endfunction

	function automatic scan_t extend(input scan_t s, input logic [7:0] c);
		scan_t t;
		logic [VALUE_W+3:0] ext, sum;
		logic [3:0] d;
		t = s;
		for (int k = 0; k < 4; k++) begin
			t.cand[k] = s.cand[k] && (s.len < LEN_W'(kw_len(2'(k))))
				&& (kw_char(2'(k), s.len[2:0]) == c);
		end
		if (s.len < LEN_W'(LENGTH_LIMIT))
			t.len = s.len + LEN_W'(1);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d   = 4'(c - CH_ZERO);
			ext = (VALUE_W+4)'(s.acc);
			sum = (ext << 3) + (ext << 1) + (VALUE_W+4)'(d);
			t.acc = (sum > (VALUE_W+4)'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_W-1:0];
		end else begin
			t.dig = 1'b0;
		end
		return t;
	endfunction

	function automatic result_t run_result(input scan_t s);
		result_t r;
		r = mk_result(KIND_IDENT, KW_COUT, 8'h00, rep_len(s.len));
		if (s.mode == MODE_DIGIT) begin
			if (s.dig) begin
				r.kind = KIND_NUMBER;
				r.val  = s.acc;
			end else begin
				r.kind = KIND_MALFORMED;
			end
		end else if (s.cand[KW_FOR] && s.len == LEN_W'(kw_len(KW_FOR))) begin
			r.kind = KIND_RESERVED;
			r.kw   = KW_FOR;
		end else if (s.cand[KW_INT] && s.len == LEN_W'(kw_len(KW_INT))) begin
			r.kind = KIND_RESERVED;
			r.kw   = KW_INT;
		end else if (s.cand[KW_WHILE] && s.len == LEN_W'(kw_len(KW_WHILE))) begin
			r.kind = KIND_RESERVED;
			r.kw   = KW_WHILE;
		end
		return r;
	endfunction

	assign c_digit   = (character >= CH_ZERO) && (character <= CH_NINE);
	assign c_alpha   = (character >= 8'h61 && character <= 8'h7A)
		|| (character >= 8'h41 && character <= 8'h5A);
	assign c_word    = c_digit || c_alpha || (character == CH_UNDER);
	assign c_special = (character == CH_EQ) || (character == CH_STAR)
		|| (character == CH_SEMI) || (character == CH_LPAR) || (character == CH_RPAR);
	assign c_oper    = (character == CH_PLUS) || (character == CH_MINUS)
		|| (character == CH_STAR) || (character == CH_SLASH);

	// Candidate results in emission order: pending cout, pending '<', ended run,
	// special symbol, operator, then the end-of-statement flush of run, cout and '<'.
	always_comb begin
		scan_t s;
		logic  done;
		s    = st_q;
		done = 1'b0;
		for (int i = 0; i < NCAND; i++) begin
			cv[i] = 1'b0;
			cr[i] = '0;
		end

		if (s.ltp == LTP_COUT) begin
			cv[0] = 1'b1;
			if (character == CH_LT) begin
				cr[0] = mk_result(KIND_RESERVED, KW_COUT, 8'h00, 8'd6);
				s.ltp = LTP_NONE;
				done  = 1'b1;
			end else begin
				cr[0] = mk_result(KIND_IDENT, KW_COUT, 8'h00, 8'd4);
				s.ltp = LTP_LT;
			end
		end
		if (!done && s.ltp == LTP_LT) begin
			s.ltp = LTP_NONE;
			cv[1] = 1'b1;
			if (character == CH_EQ) begin
				cr[1] = mk_result(KIND_SPECIAL, KW_COUT, CH_LT, 8'd2);
				done  = 1'b1;
			end else begin
				cr[1] = mk_result(KIND_LONE_LT, KW_COUT, CH_LT, 8'd1);
			end
		end
		if (!done && s.mode != MODE_NONE) begin
			if (c_word) begin
				s    = extend(s, character);
				done = 1'b1;
			end else if (s.mode == MODE_WORD && s.cand[KW_COUT]
					&& s.len == LEN_W'(kw_len(KW_COUT)) && character == CH_LT) begin
				s     = cleared(s);
				s.ltp = LTP_COUT;
				done  = 1'b1;
			end else begin
				cv[2] = 1'b1;
				cr[2] = run_result(s);
				s     = cleared(s);
			end
		end
		if (!done) begin
			if (c_digit) begin
				s      = cleared(s);
				s.mode = MODE_DIGIT;
				s      = extend(s, character);
			end else if (c_word) begin
				s      = cleared(s);
				s.mode = MODE_WORD;
				s      = extend(s, character);
			end else if (character == CH_LT) begin
				s.ltp = LTP_LT;
			end else begin
				cv[3] = c_special;
				cr[3] = mk_result(KIND_SPECIAL, KW_COUT, character, 8'd1);
				cv[4] = c_oper;
				cr[4] = mk_result(KIND_OPERATOR, KW_COUT, character, 8'd1);
			end
		end

		if (end_of_statement) begin
			cv[5] = (s.mode != MODE_NONE);
			cr[5] = run_result(s);
			cv[6] = (s.ltp == LTP_COUT);
			cr[6] = mk_result(KIND_IDENT, KW_COUT, 8'h00, 8'd4);
			cv[7] = (s.ltp != LTP_NONE);
			cr[7] = mk_result(KIND_LONE_LT, KW_COUT, CH_LT, 8'd1);
			s     = cleared(s);
			s.ltp = LTP_NONE;
		end
		st_d = s;
	end

	always_comb begin
		n_new = '0;
		for (int i = 0; i < MAX_RESULTS; i++)
			lst[i] = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cv[i] && n_new < 3'(MAX_RESULTS)) begin
				lst[n_new[1:0]] = cr[i];
				n_new = n_new + 3'd1;
			end
		end
	end

	assign out_valid = (cnt_s1 != 3'd0);
	assign at_last   = ({1'b0, idx_q} == cnt_s1 - 3'd1);
	assign out_take  = out_valid && !out_stall;
	// A new character may land in the buffer in the cycle its final beat leaves.
	assign in_stall  = out_valid && !(out_take && at_last);
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= MODE_NONE;
			st_q.len  <= '0;
			st_q.acc  <= '0;
			st_q.dig  <= 1'b1;
			st_q.cand <= 4'hF;
			st_q.ltp  <= LTP_NONE;
			cnt_s1    <= '0;
			idx_q     <= '0;
		end else if (in_take) begin
			st_q   <= st_d;
			cnt_s1 <= n_new;
			idx_q  <= '0;
		end else if (out_take) begin
			if (at_last) begin
				cnt_s1 <= '0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			for (int i = 0; i < MAX_RESULTS; i++)
				res_s1[i] <= lst[i];
		end
	end

	assign token_kind    = res_s1[idx_q].kind;
	assign keyword_index = res_s1[idx_q].kw;
	assign symbol_code   = res_s1[idx_q].sym;
	assign token_length  = res_s1[idx_q].len;
	assign number_value  = res_s1[idx_q].val;
	assign last_result   = at_last;

endmodule

`default_nettype wire

// ===== hdl/stc_checker.sv =====
// Port-level checker for the statement token classifier, bound to the top level.
`default_nettype none

module stc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  character,
	input wire logic        end_of_statement,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  token_kind,
	input wire logic [1:0]  keyword_index,
	input wire logic [7:0]  symbol_code,
	input wire logic [7:0]  token_length,
	input wire logic [30:0] number_value,
	input wire logic        last_result
);
	import stc_pkg::*;

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind)
			&& $stable(token_length) && $stable(number_value) && $stable(last_result))
		else $error("stalled result beat changed");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != KIND_NUMBER |-> number_value == 31'd0)
		else $error("value on a non-number token");

	a_lone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_LONE_LT |-> symbol_code == CH_LT
			&& token_length == 8'd1)
		else $error("lone less-than malformed");

	a_cout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_RESERVED && keyword_index == KW_COUT
			|-> token_length == 8'd6)
		else $error("cout<< with wrong length");

endmodule

bind statement_token_classifier stc_checker u_stc_checker (.*);

`default_nettype wire
